// File: src/tic_pkg.sv
package tic_pkg;

    // Table geometry defaults
    localparam int GROUPS_DEF = 8;
    localparam int STEPS_DEF  = 16;

    // Configuration port
    localparam int CFG_W = 5;
    typedef enum logic [1:0] {
        REG_TIME_DEP  = 2'd0,
        REG_TEMP_DEP  = 2'd1,
        REG_STEPS     = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    // Operation codes
    typedef enum logic [1:0] {
        OP_QUERY   = 2'd0,
        OP_WR_TIME = 2'd1,
        OP_WR_REF  = 2'd2,
        OP_WR_COEF = 2'd3
    } op_t;

    // Serial unit widths
    localparam int MUL_W  = 40;
    localparam int DVD_W  = 66;
    localparam int DVS_W  = 33;
    localparam int RAD_W  = 16;
    localparam int ROOT_W = 22;

    // sqrt(300 K) in Q16.16
    localparam logic [23:0] SQRT300_Q16 = 24'd1135116;

endpackage

// File: src/tic_mul.sv
module tic_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tic_pkg::MUL_W-1:0]      a,
    input  logic [tic_pkg::MUL_W-1:0]      b,
    output logic                           done,
    output logic [2*tic_pkg::MUL_W-1:0]    prod
);
    import tic_pkg::*;

    localparam int CW = $clog2(MUL_W + 1);

    logic [2*MUL_W-1:0] acc_reg;
    logic [MUL_W-1:0]   mcand_reg;
    logic [CW-1:0]      cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [MUL_W:0]     sum;

    // add the multiplicand when the low multiplier bit is set
    assign sum = {1'b0, acc_reg[2*MUL_W-1:MUL_W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);

    // control: one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(MUL_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift the partial product right
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= {{MUL_W{1'b0}}, b};
            mcand_reg <= a;
        end
        else if (run_reg)
        begin
            acc_reg <= {sum, acc_reg[MUL_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: src/tic_div.sv
module tic_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tic_pkg::DVD_W-1:0]   dividend,
    input  logic [tic_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [tic_pkg::DVD_W-1:0]   quotient
);
    import tic_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // restoring step: bring down one dividend bit
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(DVD_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: src/tic_sqrt.sv
module tic_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tic_pkg::RAD_W-1:0]    temperature,
    output logic                         done,
    output logic [tic_pkg::ROOT_W-1:0]   root
);
    import tic_pkg::*;

    localparam int CW   = $clog2(ROOT_W + 1);
    localparam int RW   = ROOT_W + 2;
    localparam int PADW = 2 * ROOT_W - RAD_W;

    logic [2*ROOT_W-1:0] rad_reg;
    logic [RW-1:0]       rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CW-1:0]       cnt_reg;
    logic                run_reg;
    logic                done_reg;
    logic [RW+1:0]       t;
    logic [RW+1:0]       trial;
    logic [RW+1:0]       diff;
    logic                ge;

    // one root bit per cycle from two radicand bits
    assign t     = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(ROOT_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {temperature, {PADW{1'b0}}};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= ge ? diff[RW-1:0] : t[RW-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: src/time_interpolated_cross_section.sv
// Time-interpolated cross section. Beats with operation 1..3 write the time
// table, the reference table or a group's temperature coefficient in the
// cycle they are taken and produce no result. A query beat walks the time
// table one entry per cycle, then on a segment of nonzero length runs a
// bit-serial multiply and a restoring divide, and with the temperature
// correction on a square root and two more serial multiplies; busy stays
// high meanwhile. The result appears on cross_section and saturated for
// exactly one cycle with result_valid high and must be captured then; the
// receiver cannot stall it. A query on a group outside the table returns
// zero in the next cycle.
module time_interpolated_cross_section #(
    parameter int GROUPS = tic_pkg::GROUPS_DEF,
    parameter int STEPS  = tic_pkg::STEPS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [tic_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 operation,
    input  logic [2:0]                 group,
    input  logic [3:0]                 step,
    input  logic signed [31:0]         value,
    input  logic [31:0]                now_time,
    input  logic [15:0]                temperature,
    output logic                       result_valid,
    output logic signed [31:0]         cross_section,
    output logic                       saturated
);
    import tic_pkg::*;

    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int RW = $clog2(STEPS * GROUPS);
    localparam int IW = $clog2(STEPS + 1);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_RD0   = 12'b000000000010,
        ST_LD0   = 12'b000000000100,
        ST_SCAN  = 12'b000000001000,
        ST_R0W   = 12'b000000010000,
        ST_R1W   = 12'b000000100000,
        ST_MUL   = 12'b000001000000,
        ST_DIV   = 12'b000010000000,
        ST_TCHK  = 12'b000100000000,
        ST_SQRT  = 12'b001000000000,
        ST_TMUL1 = 12'b010000000000,
        ST_TMUL2 = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic                time_dep_reg;
    logic                temp_dep_reg;
    logic [CFG_W-1:0]    steps_reg;

    // tables
    logic [31:0] tp_mem   [STEPS];
    logic [31:0] ref_mem  [STEPS*GROUPS];
    logic [31:0] coef_mem [GROUPS];
    logic [31:0] tp_q_reg;
    logic [31:0] ref_q_reg;
    logic [31:0] coef_q_reg;
    logic [SW-1:0] tp_ra;
    logic [RW-1:0] ref_ra;

    // query context
    logic [2:0]          g_reg;
    logic [31:0]         now_reg;
    logic [15:0]         temp_reg;
    logic [IW-1:0]       idx_reg;
    logic [31:0]         t0_reg;
    logic [31:0]         t1_reg;
    logic signed [31:0]  r0_reg;
    logic signed [31:0]  xs_reg;
    logic                flag_reg;
    logic                neg_reg;
    logic [DVS_W-1:0]    dt_mag_reg;

    // output
    logic                valid_reg;
    logic signed [31:0]  cs_reg;
    logic                sat_reg;

    // serial units
    logic                   mul_start;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic                   mul_done;
    logic [2*MUL_W-1:0]     mul_prod;
    logic                   div_start;
    logic                   div_done;
    logic [DVD_W-1:0]       div_q;
    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [ROOT_W-1:0]      sqrt_root;

    logic                accept;
    logic                grp_ok;
    logic                stp_ok;
    logic [IW-1:0]       n_c;
    logic                found;
    logic                last;
    logic signed [32:0]  a_c;
    logic signed [32:0]  b_c;
    logic signed [32:0]  dt_c;
    logic [33:0]         q_c;
    logic signed [35:0]  isum_c;
    logic [32:0]         iclamp_c;
    logic signed [23:0]  d_c;
    logic [MUL_W-1:0]    pm_c;
    logic signed [39:0]  f_c;
    logic [32:0]         tq_c;
    logic signed [35:0]  tval_c;
    logic [32:0]         tclamp_c;
    logic                tovf_c;

    function automatic logic [32:0] abs33(input logic signed [32:0] x);
        return x[32] ? 33'(-x) : 33'(x);
    endfunction

    // {flag, value}: clamp to signed 32 bits
    function automatic logic [32:0] clamp36(input logic signed [35:0] v);
        if (v > 36'sh07FFFFFFF)
            return {1'b1, 32'h7FFFFFFF};
        else if (v < -36'sh080000000)
            return {1'b1, 32'h80000000};
        else
            return {1'b0, v[31:0]};
    endfunction

    assign accept = start && !busy;
    assign grp_ok = int'(group) < GROUPS;
    assign stp_ok = int'(step) < STEPS;
    assign n_c    = (int'(steps_reg) > STEPS) ? IW'(STEPS) : IW'(steps_reg);
    assign found  = now_reg <= tp_q_reg;
    assign last   = (int'(idx_reg) + 1) >= int'(n_c);

    // interpolation terms
    assign a_c  = $signed({1'b0, now_reg}) - $signed({1'b0, t0_reg});
    assign b_c  = $signed({ref_q_reg[31], ref_q_reg}) - $signed({r0_reg[31], r0_reg});
    assign dt_c = $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});

    assign q_c = ((|div_q[DVD_W-1:34]) || (div_q[33:0] > 34'h200000000))
                 ? 34'h200000000 : div_q[33:0];
    assign isum_c   = $signed({{4{r0_reg[31]}}, r0_reg})
                      + (neg_reg ? -$signed({2'b00, q_c}) : $signed({2'b00, q_c}));
    assign iclamp_c = clamp36(isum_c);

    // temperature terms
    assign d_c  = $signed({2'b00, sqrt_root}) - $signed(SQRT300_Q16);
    assign pm_c = mul_prod[MUL_W+15:16];
    assign f_c  = 40'sh0001000000 + (neg_reg ? -$signed(pm_c) : $signed(pm_c));
    assign tovf_c   = |mul_prod[2*MUL_W-1:64];
    assign tq_c     = (mul_prod[63:24] > 40'h100000000) ? 33'h100000000 : mul_prod[56:24];
    assign tval_c   = neg_reg ? -$signed({3'b000, tq_c}) : $signed({3'b000, tq_c});
    assign tclamp_c = clamp36(tval_c);

    // read addresses
    always_comb
    begin
        tp_ra  = (state_reg == ST_SCAN) ? SW'(idx_reg + 1'b1) : SW'(idx_reg);
        ref_ra = RW'(int'(g_reg));
        unique case (state_reg)
            ST_SCAN: ref_ra = RW'((int'(idx_reg) - 1) * GROUPS + int'(g_reg));
            ST_R0W:  ref_ra = RW'(int'(idx_reg) * GROUPS + int'(g_reg));
            default: ref_ra = RW'(int'(g_reg));
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = {{(MUL_W-33){1'b0}}, abs33(a_c)};
        mul_b      = {{(MUL_W-33){1'b0}}, abs33(b_c)};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_QUERY && grp_ok)
                    state_next = ST_RD0;
            end
            ST_RD0:
                state_next = ST_LD0;
            ST_LD0:
            begin
                if (time_dep_reg && n_c > IW'(1))
                    state_next = ST_SCAN;
                else
                    state_next = ST_TCHK;
            end
            ST_SCAN:
            begin
                if (found)
                    state_next = ST_R0W;
                else if (last)
                    state_next = ST_TCHK;
            end
            ST_R0W:
                state_next = ST_R1W;
            ST_R1W:
            begin
                if (dt_c == '0)
                    state_next = ST_TCHK;
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_TCHK;
            end
            ST_TCHK:
            begin
                if (temp_dep_reg)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_SQRT:
            begin
                mul_a = {{(MUL_W-33){1'b0}}, abs33($signed({coef_q_reg[31], coef_q_reg}))};
                mul_b = {{(MUL_W-24){1'b0}}, (d_c[23] ? 24'(-d_c) : 24'(d_c))};
                if (sqrt_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_TMUL1;
                end
            end
            ST_TMUL1:
            begin
                mul_a = {{(MUL_W-33){1'b0}}, abs33($signed({xs_reg[31], xs_reg}))};
                mul_b = f_c[39] ? MUL_W'(-f_c) : MUL_W'(f_c);
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_TMUL2;
                end
            end
            ST_TMUL2:
            begin
                if (mul_done)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            time_dep_reg <= 1'b0;
            temp_dep_reg <= 1'b0;
            steps_reg    <= CFG_W'(1);
            idx_reg      <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TIME_DEP: time_dep_reg <= cfg_data[0];
                    REG_TEMP_DEP: temp_dep_reg <= cfg_data[0];
                    REG_STEPS:    steps_reg    <= cfg_data;
                    default:      ;
                endcase
            end
            // advance the table walk
            if (state_reg == ST_IDLE)
                idx_reg <= '0;
            else if (state_reg == ST_RD0)
                idx_reg <= IW'(1);
            else if (state_reg == ST_SCAN && !found)
                idx_reg <= idx_reg + 1'b1;
            valid_reg <= (accept && operation == OP_QUERY && !grp_ok)
                      || (state_reg == ST_TCHK && !temp_dep_reg)
                      || (state_reg == ST_TMUL2 && mul_done);
        end
    end

    // tables: write on a write beat, registered reads
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_WR_TIME && stp_ok)
            tp_mem[SW'(step)] <= value;
        tp_q_reg <= tp_mem[tp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_WR_REF && stp_ok && grp_ok)
            ref_mem[RW'(int'(step) * GROUPS + int'(group))] <= value;
        ref_q_reg <= ref_mem[ref_ra];
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_WR_COEF && grp_ok)
            coef_mem[GW'(group)] <= value;
        coef_q_reg <= coef_mem[GW'(g_reg)];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                g_reg    <= group;
                now_reg  <= now_time;
                temp_reg <= temperature;
                flag_reg <= 1'b0;
                if (accept && operation == OP_QUERY && !grp_ok)
                begin
                    cs_reg  <= '0;
                    sat_reg <= 1'b0;
                end
            end
            ST_LD0:
            begin
                xs_reg <= ref_q_reg;
                t0_reg <= tp_q_reg;
            end
            ST_SCAN:
            begin
                if (found)
                    t1_reg <= tp_q_reg;
                else
                    t0_reg <= tp_q_reg;
            end
            ST_R0W:
                r0_reg <= ref_q_reg;
            ST_R1W:
            begin
                neg_reg    <= a_c[32] ^ b_c[32] ^ dt_c[32];
                dt_mag_reg <= abs33(dt_c);
                // zero segment length
                if (dt_c == '0)
                begin
                    flag_reg <= 1'b1;
                    if (a_c == '0 || b_c == '0)
                        xs_reg <= r0_reg;
                    else if (a_c[32] ^ b_c[32])
                        xs_reg <= 32'sh80000000;
                    else
                        xs_reg <= 32'sh7FFFFFFF;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    xs_reg   <= iclamp_c[31:0];
                    flag_reg <= flag_reg | iclamp_c[32];
                end
            end
            ST_TCHK:
            begin
                if (!temp_dep_reg)
                begin
                    cs_reg  <= xs_reg;
                    sat_reg <= flag_reg;
                end
            end
            ST_SQRT:
                neg_reg <= coef_q_reg[31] ^ d_c[23];
            ST_TMUL1:
            begin
                if (mul_done)
                    neg_reg <= xs_reg[31] ^ f_c[39];
            end
            ST_TMUL2:
            begin
                if (mul_done)
                begin
                    if (tovf_c)
                    begin
                        cs_reg  <= neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        cs_reg  <= tclamp_c[31:0];
                        sat_reg <= flag_reg | tclamp_c[32];
                    end
                end
            end
            default: ;
        endcase
    end

    tic_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tic_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod[DVD_W-1:0]),
        .divisor  (dt_mag_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    tic_sqrt u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (sqrt_start),
        .temperature (temp_reg),
        .done        (sqrt_done),
        .root        (sqrt_root)
    );

    assign busy          = state_reg != ST_IDLE;
    assign result_valid  = valid_reg;
    assign cross_section = cs_reg;
    assign saturated     = sat_reg;

endmodule

// File: src/tic_checker.sv
module tic_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       result_valid
);
    import tic_pkg::*;

    // a query beat either finishes at once or keeps the block busy
    a_query_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_QUERY |=> busy || result_valid)
        else $error("query beat left no trace");

    // a write beat produces no result beat and no busy period
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation != OP_QUERY |=> !busy && !result_valid)
        else $error("write beat caused activity");

    // a result beat is shown only once the block is free again
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

    // busy only rises on a taken beat
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind time_interpolated_cross_section tic_checker u_tic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .result_valid (result_valid)
);

// File: dv/tb_time_interpolated_cross_section.sv
module tb_time_interpolated_cross_section;
    import tic_pkg::*;

    typedef struct packed {
        op_t         op;
        logic [2:0]  grp;
        logic [3:0]  stp;
        logic [31:0] word;
        logic [31:0] now;
        logic [15:0] temp;
    } beat_t;

    typedef struct packed {
        logic signed [31:0] xs;
        logic               sat;
    } xs_result_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        beat_t       beat;
        reg_idx_t    reg_sel;
        logic [4:0]  reg_val;
        logic        typed;
        xs_result_t  want;
    } row_t;

    localparam int NGRP = GROUPS_DEF;
    localparam int NSTP = STEPS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               start;
    logic               busy;
    logic [1:0]         operation;
    logic [2:0]         group;
    logic [3:0]         step;
    logic signed [31:0] value;
    logic [31:0]        now_time;
    logic [15:0]        temperature;
    logic               result_valid;
    logic signed [31:0] cross_section;
    logic               saturated;

    // predictor state
    logic [31:0] time_tab [NSTP];
    int          ref_tab [NSTP*NGRP];
    int          coef_tab [NGRP];
    logic        mode_time;
    logic        mode_temp;
    logic [4:0]  steps_used;

    xs_result_t pending_xs [$];
    int         fail_count;
    int         idle_cycles;
    bit         burst_mode;

    time_interpolated_cross_section dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .group         (group),
        .step          (step),
        .value         (value),
        .now_time      (now_time),
        .temperature   (temperature),
        .result_valid  (result_valid),
        .cross_section (cross_section),
        .saturated     (saturated)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic int clamp32(longint v, inout logic flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int lerp_segment(logic [31:0] now, logic [31:0] t0, logic [31:0] t1,
                                        int r0, int r1, inout logic flag);
        longint      a;
        longint      b;
        longint      dt;
        logic        neg;
        logic [63:0] q;
        a = longint'(now) - longint'(t0);
        b = longint'(r1) - longint'(r0);
        dt = longint'(t1) - longint'(t0);
        neg = (a < 0) != (b < 0);
        // flat segment: saturate toward the slope sign
        if (dt == 0)
        begin
            flag = 1'b1;
            if (a == 0 || b == 0)
                return r0;
            return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        if (dt < 0)
            neg = !neg;
        q = (mag(a) * mag(b)) / mag(dt);
        if (q > (64'd1 << 33))
            q = 64'd1 << 33;
        return clamp32(longint'(r0) + (neg ? -longint'(q) : longint'(q)), flag);
    endfunction

    function automatic int temp_scale(int xs, int gamma, logic [15:0] temp, inout logic flag);
        longint      d;
        longint      f;
        logic [63:0] ux;
        logic [63:0] uf;
        logic [63:0] q;
        logic        neg;
        d = longint'(int_sqrt(64'(temp) << 28)) - 64'sd1135116;
        f = 64'sd16777216 + (longint'(gamma) * d) / 64'sd65536;
        ux = mag(longint'(xs));
        uf = mag(f);
        neg = (xs < 0) != (f < 0);
        if (ux == 0 || uf == 0)
            return 0;
        if (uf > 64'hFFFF_FFFF_FFFF_FFFF / ux)
        begin
            flag = 1'b1;
            return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        q = (ux * uf) >> 24;
        if (q > (64'd1 << 32))
            q = 64'd1 << 32;
        return clamp32(neg ? -longint'(q) : longint'(q), flag);
    endfunction

    // Apply one beat to the table copy; return 1 with the cross section for a query
    function automatic logic eval_beat(beat_t bt, output xs_result_t res);
        logic flag;
        int   xs;
        int   n;
        flag = 1'b0;
        res = '0;
        case (bt.op)
            OP_WR_TIME: time_tab[bt.stp] = bt.word;
            OP_WR_REF:  ref_tab[bt.stp*NGRP + bt.grp] = int'(bt.word);
            OP_WR_COEF: coef_tab[bt.grp] = int'(bt.word);
            default:
            begin
                xs = ref_tab[bt.grp];
                if (mode_time)
                begin
                    n = (steps_used > NSTP) ? NSTP : steps_used;
                    for (int i = 1; i < n; i++)
                    begin
                        if (bt.now <= time_tab[i])
                        begin
                            xs = lerp_segment(bt.now, time_tab[i-1], time_tab[i],
                                              ref_tab[(i-1)*NGRP + bt.grp],
                                              ref_tab[i*NGRP + bt.grp], flag);
                            break;
                        end
                    end
                end
                if (mode_temp)
                    xs = temp_scale(xs, coef_tab[bt.grp], bt.temp, flag);
                res.xs = xs;
                res.sat = flag;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Drive one beat after a random gap (none in burst mode) and hold it until taken
    task automatic send_beat(beat_t bt, logic typed, xs_result_t want);
        int         gap;
        xs_result_t res;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= bt.op;
        group       <= bt.grp;
        step        <= bt.stp;
        value       <= bt.word;
        now_time    <= bt.now;
        temperature <= bt.temp;
        do
            @(posedge clk);
        while (busy);
        if (eval_beat(bt, res))
            pending_xs.push_back(typed ? want : res);
    endtask

    // Write a register once the block has drained
    task automatic write_reg(reg_idx_t idx, logic [4:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (pending_xs.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_TIME_DEP: mode_time = data[0];
            REG_TEMP_DEP: mode_temp = data[0];
            REG_STEPS:    steps_used = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom) >>> $urandom_range(4, 16));
        endcase
    endfunction

    task automatic load_sorted_times();
        beat_t      bt;
        logic [31:0] t;
        t = $urandom_range(0, 1 << 20);
        for (int s = 0; s < NSTP; s++)
        begin
            bt = '{OP_WR_TIME, 3'($urandom), 4'(s), t, $urandom, 16'($urandom)};
            send_beat(bt, 1'b0, '0);
            t = t + $urandom_range(0, 1 << 27);
        end
    endtask

    task automatic random_beat();
        beat_t       bt;
        int          k;
        logic [31:0] hi;
        bt = '{OP_QUERY, 3'($urandom), 4'($urandom), rand_word(), $urandom, 16'($urandom)};
        k = bt.stp;
        case ($urandom_range(0, 19))
            0, 1:
            begin
                // keep the time table ordered, or flatten or break a segment
                bt.op = OP_WR_TIME;
                if (k > 0 && k < NSTP-1 && time_tab[k+1] >= time_tab[k-1])
                begin
                    hi = time_tab[k+1];
                    case ($urandom_range(0, 4))
                        0: bt.word = time_tab[k-1];
                        1: bt.word = $urandom;
                        default: bt.word = time_tab[k-1] + (hi - time_tab[k-1]) / 2;
                    endcase
                end
            end
            2, 3: bt.op = OP_WR_REF;
            4:    bt.op = OP_WR_COEF;
            default:
            begin
                if ($urandom_range(0, 9) < 7)
                    bt.now = time_tab[k] - ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1 << 26));
                if ($urandom_range(0, 1))
                    bt.temp = $urandom_range(3000, 20000);
            end
        endcase
        send_beat(bt, 1'b0, '0);
    endtask

    row_t dir_rows [] = '{
        '{ROW_BEAT, '{OP_WR_REF,  3'd3, 4'd0, 32'h7FFFFFFF, 32'd0, 16'd0}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd3, 4'd9, 32'd0, 32'hFFFFFFFF, 16'hFFFF}, REG_UNUSED, 5'd0,
          1'b1, '{32'sh7FFFFFFF, 1'b0}},
        '{ROW_BEAT, '{OP_WR_REF,  3'd0, 4'd0, 32'h80000000, 32'd0, 16'd0}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'd0, 16'd0}, REG_UNUSED, 5'd0,
          1'b1, '{32'sh80000000, 1'b0}},
        '{ROW_BEAT, '{OP_WR_TIME, 3'd5, 4'd0, 32'd0, 32'd0, 16'd0}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_WR_TIME, 3'd7, 4'd1, 32'd0, 32'd0, 16'd0}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_WR_REF,  3'd0, 4'd1, 32'h00010000, 32'd0, 16'd0}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_CFG,  '0, REG_TIME_DEP, 5'd1, 1'b0, '0},
        '{ROW_CFG,  '0, REG_STEPS,    5'd2, 1'b0, '0},
        // flat segment at its end point keeps the start value and flags
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'd0, 16'd0}, REG_UNUSED, 5'd0,
          1'b1, '{32'sh80000000, 1'b1}},
        // past the last time point: step-0 value, no flag
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'd5, 16'd0}, REG_UNUSED, 5'd0,
          1'b1, '{32'sh80000000, 1'b0}},
        '{ROW_BEAT, '{OP_WR_TIME, 3'd0, 4'd1, 32'hFFFFFFFF, 32'd0, 16'd0}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'hFFFFFFFF, 16'd0}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'h80000000, 16'd0}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_BEAT, '{OP_WR_COEF, 3'd0, 4'd9, 32'h7FFFFFFF, 32'd0, 16'd0}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_CFG,  '0, REG_TEMP_DEP, 5'd1, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'd0, 16'hFFFF}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'd123, 16'd0}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_WR_COEF, 3'd3, 4'd0, 32'h80000000, 32'd0, 16'd0}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_BEAT, '{OP_WR_REF,  3'd3, 4'd1, 32'd0, 32'd0, 16'd0}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd3, 4'd0, 32'd0, 32'd7, 16'd4800}, REG_UNUSED, 5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd3, 4'd0, 32'd0, 32'hFFFFFFFF, 16'hFFFF}, REG_UNUSED, 5'd0,
          1'b0, '0},
        '{ROW_CFG,  '0, REG_STEPS,    5'd0, 1'b0, '0},
        '{ROW_BEAT, '{OP_QUERY,   3'd0, 4'd0, 32'd0, 32'd0, 16'd9000}, REG_UNUSED, 5'd0, 1'b0, '0}
    };

    // time_dep, temp_dep, steps per random phase
    logic [4:0] phase_cfg [8][3] = '{
        '{5'd1, 5'd0, 5'd16}, '{5'd1, 5'd1, 5'd16}, '{5'd0, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd31},
        '{5'd1, 5'd0, 5'd0},  '{5'd1, 5'd1, 5'd17}, '{5'd0, 5'd0, 5'd5}, '{5'd1, 5'd1, 5'd3}
    };

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        xs_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_xs.size() == 0)
            begin
                $error("result beat with nothing expected: xs %h sat %b",
                       cross_section, saturated);
                fail_count++;
            end
            else
            begin
                exp_r = pending_xs.pop_front();
                if (cross_section !== exp_r.xs)
                begin
                    $error("cross_section expected %h actual %h", exp_r.xs, cross_section);
                    fail_count++;
                end
                if (saturated !== exp_r.sat)
                begin
                    $error("saturated expected %b actual %b", exp_r.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        beat_t bt;
        fail_count  = 0;
        idle_cycles = 0;
        burst_mode  = 1'b0;
        mode_time   = 1'b0;
        mode_temp   = 1'b0;
        steps_used  = 5'd1;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        start       = 1'b0;
        operation   = '0;
        group       = '0;
        step        = '0;
        value       = '0;
        now_time    = '0;
        temperature = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
        end

        // fill every table entry before random queries
        load_sorted_times();
        for (int s = 0; s < NSTP; s++)
            for (int g = 0; g < NGRP; g++)
            begin
                bt = '{OP_WR_REF, 3'(g), 4'(s), rand_word(), $urandom, 16'($urandom)};
                send_beat(bt, 1'b0, '0);
            end
        for (int g = 0; g < NGRP; g++)
        begin
            bt = '{OP_WR_COEF, 3'(g), 4'($urandom), rand_word(), $urandom, 16'($urandom)};
            send_beat(bt, 1'b0, '0);
        end

        // random phases under several settings
        foreach (phase_cfg[p])
        begin
            write_reg(REG_TIME_DEP, phase_cfg[p][0]);
            write_reg(REG_TEMP_DEP, phase_cfg[p][1]);
            write_reg(REG_STEPS, phase_cfg[p][2]);
            load_sorted_times();
            for (int n = 0; n < 130; n++)
            begin
                if (n % 26 == 0)
                    burst_mode = ($urandom_range(0, 2) == 0);
                random_beat();
            end
        end

        start <= 1'b0;
        while (pending_xs.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
src/tic_pkg.sv
src/tic_mul.sv
src/tic_div.sv
src/tic_sqrt.sv
src/time_interpolated_cross_section.sv
src/tic_checker.sv
dv/tb_time_interpolated_cross_section.sv
